[design/rss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_pkg: shared types and codes of the ranked sorted set
// Operation and status codes and the control group that the top level sends
// to every cell of the chain.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int RankWidth     = 9;
  localparam int PositionWidth = 8;
  localparam int StatusWidth   = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  // Control broadcast from the sequencer to all cells.
  typedef struct packed {
    logic capture;  // request accepted: cells evaluate their compare flags
    logic apply;    // cells shift or load according to the captured flags
    logic remove;   // captured request is a remove
  } ctrl_t;

endpackage
`default_nettype wire

[design/rss_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_req_if / rss_rsp_if: request and response channels
// Valid/ready channels; a request moves at a clock edge with valid and
// ready both high.
// ----------------------------------------------------------------------------
interface rss_req_if #(
  parameter int VALUE_WIDTH = 17
);
  import rss_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [VALUE_WIDTH-1:0]   height;
  logic [PositionWidth-1:0] position;

  modport source (output valid, output operation, output height, output position,
                  input ready);
  modport sink   (input valid, input operation, input height, input position,
                  output ready);
endinterface

interface rss_rsp_if;
  import rss_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [RankWidth-1:0]   rank;
  logic [StatusWidth-1:0] status;

  modport source (output valid, output rank, output status, input ready);
  modport sink   (input valid, input rank, input status, output ready);
endinterface
`default_nettype wire

[design/rss_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_cell: one slot of the sorted chain
// Holds one value. On capture it compares its value with the new key and its
// index with the remove position; on apply it holds, loads the key, or takes
// the value of its left or right neighbor.
// ----------------------------------------------------------------------------
module rss_cell #(
  parameter int VALUE_WIDTH = 17,
  parameter int COUNT_WIDTH = 9,
  parameter int IDX         = 0
) (
  input  wire logic                             clk_i,
  input  wire rss_pkg::ctrl_t                   ctrl_i,
  input  wire logic [VALUE_WIDTH-1:0]           cap_key_i,
  input  wire logic [rss_pkg::PositionWidth-1:0] cap_pos_i,
  input  wire logic [COUNT_WIDTH-1:0]           count_i,
  input  wire logic [VALUE_WIDTH-1:0]           ins_key_i,
  input  wire logic [VALUE_WIDTH-1:0]           left_val_i,
  input  wire logic                             left_gt_i,
  input  wire logic [VALUE_WIDTH-1:0]           right_val_i,
  output logic      [VALUE_WIDTH-1:0]           val_o,
  output logic                                  gt_o,
  output logic                                  bnd_o
);
  import rss_pkg::*;

  logic [VALUE_WIDTH-1:0] val_q;
  logic                   gt_q;
  logic                   ge_pos_q;
  logic                   occupied;

  assign occupied = 32'(IDX) < 32'(count_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      gt_q     <= occupied && (val_q > cap_key_i);
      ge_pos_q <= 32'(IDX) >= 32'(cap_pos_i);
    end
  end

  // Entries above the fill level shift garbage along, which is never read.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.apply) begin
      if (ctrl_i.remove) begin
        if (ge_pos_q) begin
          val_q <= right_val_i;
        end
      end else if (!gt_q) begin
        if (left_gt_i) begin
          val_q <= ins_key_i;
        end else begin
          val_q <= left_val_i;
        end
      end
    end
  end

  assign val_o = val_q;
  assign gt_o  = gt_q;
  // The insertion point is the first cell whose value is not greater.
  assign bnd_o = left_gt_i & ~gt_q;

endmodule
`default_nettype wire

[design/ranked_sorted_set_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ranked_sorted_set_unit: sorted multiset with rank addressing
// A chain of cells that keeps values in descending order.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request: operation (insert or remove), height (value
//   to insert) and position (rank to remove, zero is the largest value).
//   rsp_o returns one response per request: rank taken by an inserted value
//   and a status (inserted, removed, store full, position out of range).
//   A request is taken when the unit is idle. At that edge every cell
//   compares its value with the key in parallel; once the output register
//   is free, the cells from the insertion point or remove position onward
//   shift by one place (unless full or out of range) and the response is
//   registered. A new request is taken only once the last one is applied.
//   If the receiver stalls, the response stays in the output register and
//   the next request is still taken and evaluated; its shift waits until
//   the output register is free.
//   Reset empties the store at once (fill count cleared); stored values are
//   not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module ranked_sorted_set_unit #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 17
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rss_req_if.sink   req_i,
  rss_rsp_if.source rsp_o
);
  import rss_pkg::*;

  localparam int CountWidth = $clog2(CAPACITY + 1);
  localparam int IdxWidth   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_e;

  state_e                   state_q;
  logic [CountWidth-1:0]    count_q;
  logic                     remove_q;
  logic [VALUE_WIDTH-1:0]   key_q;
  logic [PositionWidth-1:0] pos_q;
  logic                     rsp_valid_q;
  logic [RankWidth-1:0]     rank_q;
  logic [StatusWidth-1:0]   status_q;

  ctrl_t                    ctrl;
  logic                     accept;
  logic                     apply;
  logic                     full;
  logic                     out_of_range;

  logic [VALUE_WIDTH-1:0]   vals [CAPACITY];
  logic [CAPACITY-1:0]      gts;
  logic [CAPACITY-1:0]      bnds;
  logic [IdxWidth-1:0]      enc;
  logic [IdxWidth+8:0]      enc_ext;
  logic [RankWidth-1:0]     ins_rank;

  assign req_i.ready  = (state_q == S_IDLE);
  assign accept       = req_i.valid && req_i.ready;
  assign apply        = (state_q == S_BUSY) && (!rsp_valid_q || rsp_o.ready);
  assign full         = count_q >= CountWidth'(CAPACITY);
  assign out_of_range = 32'(pos_q) >= 32'(count_q);

  assign ctrl.capture = accept;
  assign ctrl.remove  = remove_q;
  assign ctrl.apply   = apply && (remove_q ? !out_of_range : !full);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_val;
    logic                   left_gt;
    logic [VALUE_WIDTH-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = vals[i];
      assign left_gt  = 1'b1;
    end else begin : g_mid
      assign left_val = vals[i-1];
      assign left_gt  = gts[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_inner
      assign right_val = vals[i+1];
    end

    rss_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .COUNT_WIDTH(CountWidth),
      .IDX        (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .cap_key_i  (req_i.height),
      .cap_pos_i  (req_i.position),
      .count_i    (count_q),
      .ins_key_i  (key_q),
      .left_val_i (left_val),
      .left_gt_i  (left_gt),
      .right_val_i(right_val),
      .val_o      (vals[i]),
      .gt_o       (gts[i]),
      .bnd_o      (bnds[i])
    );
  end

  // The boundary is one-hot when the store is not full, so an OR of the
  // indexes gives its position.
  always_comb begin
    enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnds[i]) begin
        enc = enc | IdxWidth'(i);
      end
    end
  end

  assign enc_ext  = {9'd0, enc};
  assign ins_rank = enc_ext[RankWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      remove_q    <= 1'b0;
      key_q       <= '0;
      pos_q       <= '0;
      rank_q      <= '0;
      status_q    <= ST_INSERTED;
    end else begin
      if (rsp_o.ready && !apply) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            remove_q <= (req_i.operation == OP_REMOVE);
            key_q    <= req_i.height;
            pos_q    <= req_i.position;
            state_q  <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (apply) begin
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            if (remove_q) begin
              rank_q <= '0;
              if (out_of_range) begin
                status_q <= ST_RANGE;
              end else begin
                status_q <= ST_REMOVED;
                count_q  <= count_q - CountWidth'(1);
              end
            end else if (full) begin
              rank_q   <= '0;
              status_q <= ST_FULL;
            end else begin
              status_q <= ST_INSERTED;
              rank_q   <= ins_rank;
              count_q  <= count_q + CountWidth'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.rank   = rank_q;
  assign rsp_o.status = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAPACITY)
    else $error("fill count exceeds capacity");

  a_boundary_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BUSY) && !remove_q && !full |-> $onehot(bnds))
    else $error("insertion boundary is not one-hot");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply && !remove_q && !full |=> count_q == $past(count_q) + CountWidth'(1))
    else $error("insert did not raise the fill count");

  a_rank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (status_q != ST_INSERTED) |-> rank_q == '0)
    else $error("nonzero rank on a response other than insert");

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_o.ready |=> rsp_valid_q && $stable(status_q))
    else $error("stalled response changed");

endmodule
`default_nettype wire
